// ----- design/open_loop_speed_ramp_angle_gen_unit_assert.svh -----
// assertion macros for the open-loop speed ramp and angle generator
`ifndef OPEN_LOOP_SPEED_RAMP_ANGLE_GEN_UNIT_ASSERT_SVH
`define OPEN_LOOP_SPEED_RAMP_ANGLE_GEN_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define OLSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define OLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/olsr_pkg.sv -----
// shared types, constants and control program of the speed ramp angle generator
`timescale 1ns / 1ps
package olsr_pkg;

  localparam int AngleBitsDef = 24;
  localparam int AdcBitsDef   = 12;

  localparam int RawW     = 12;
  localparam int StepW    = 23;
  localparam int GainW    = 16;
  localparam int SpeedW   = 24;
  localparam int QW       = 16;
  localparam int ModeW    = 3;
  localparam int DirW     = 2;
  localparam int ErrW     = 2;
  localparam int AngOutW  = 24;
  localparam int BusOutW  = 16;
  localparam int RegIdxW  = 3;
  localparam int CfgDataW = 23;
  localparam int MulAW    = 24;
  localparam int MulBW    = GainW;
  localparam int MulW     = MulAW + MulBW;
  localparam int PcW      = 3;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_RAMP_THRESHOLD = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ACCEL_STEP     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_DECEL_STEP     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_SPEED_GAIN     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_BUS_GAIN       = 3'd4;
  localparam logic [RegIdxW-1:0] REG_ANGLE_GAIN     = 3'd5;
  localparam logic [RegIdxW-1:0] REG_Q_CURRENT      = 3'd6;

  // register reset values
  localparam logic [StepW-1:0] RstRampThreshold = 23'd2560;
  localparam logic [StepW-1:0] RstAccelStep     = 23'd64;
  localparam logic [StepW-1:0] RstDecelStep     = 23'd64;
  localparam logic [GainW-1:0] RstSpeedGain     = 16'd4096;
  localparam logic [GainW-1:0] RstBusGain       = 16'd4096;
  localparam logic [GainW-1:0] RstAngleGain     = 16'd256;

  // requested modes
  localparam logic [ModeW-1:0] MODE_FREE = 3'd0;
  localparam logic [ModeW-1:0] MODE_STOP = 3'd1;
  localparam logic [ModeW-1:0] MODE_CW   = 3'd2;
  localparam logic [ModeW-1:0] MODE_CCW  = 3'd3;
  localparam logic [ModeW-1:0] MODE_NONE = 3'd7;

  // rotation direction
  localparam logic [DirW-1:0] DIR_STILL = 2'd0;
  localparam logic [DirW-1:0] DIR_CW    = 2'd1;
  localparam logic [DirW-1:0] DIR_CCW   = 2'd2;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE   = 2'd0;
  localparam logic [ErrW-1:0] ERR_MODE   = 2'd1;
  localparam logic [ErrW-1:0] ERR_NO_BUS = 2'd2;

  // program steps
  localparam logic [PcW-1:0] STEP_MUL_BUS = 3'd0;
  localparam logic [PcW-1:0] STEP_MUL_SPD = 3'd1;
  localparam logic [PcW-1:0] STEP_UPDATE  = 3'd2;
  localparam logic [PcW-1:0] STEP_RAMP    = 3'd3;
  localparam logic [PcW-1:0] STEP_MUL_ANG = 3'd4;
  localparam logic [PcW-1:0] STEP_FINISH  = 3'd5;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_BUS,
    MUL_SPD,
    MUL_ANG
  } mul_op_t;

  typedef struct packed {
    mul_op_t        mul_op;
    logic           take_bus;
    logic           update;
    logic           ramp;
    logic           finish;
    logic           jmp_nrun;
    logic [PcW-1:0] jmp_to;
    logic           last;
  } ctrl_t;

  typedef struct packed {
    ctrl_t word;
    logic  fire;
  } seq_ctl_t;

  // control store
  function automatic ctrl_t prog_word(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      STEP_MUL_BUS: begin
        w.mul_op = MUL_BUS;
      end
      STEP_MUL_SPD: begin
        w.mul_op   = MUL_SPD;
        w.take_bus = 1'b1;
      end
      STEP_UPDATE: begin
        w.update = 1'b1;
      end
      STEP_RAMP: begin
        w.ramp     = 1'b1;
        w.jmp_nrun = 1'b1;
        w.jmp_to   = STEP_FINISH;
      end
      STEP_MUL_ANG: begin
        w.mul_op = MUL_ANG;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // clamp a 25-bit sum to the signed 24-bit speed range
  function automatic logic signed [SpeedW-1:0] sat_speed(input logic signed [SpeedW:0] v);
    logic signed [SpeedW-1:0] r;
    if (v[SpeedW] != v[SpeedW-1]) begin
      r = v[SpeedW] ? {1'b1, {(SpeedW-1){1'b0}}} : {1'b0, {(SpeedW-1){1'b1}}};
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/olsr_in_if.sv -----
// input channel: one control period of samples and requests
`timescale 1ns / 1ps
interface olsr_in_if;
  import olsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [RawW-1:0]  speed_raw;
  logic [RawW-1:0]  bus_raw;
  logic [ModeW-1:0] req_mode;
  logic             fault_in;
  logic             run_request;

  modport source (
    output valid, speed_raw, bus_raw, req_mode, fault_in, run_request,
    input  ready
  );
  modport sink (
    input  valid, speed_raw, bus_raw, req_mode, fault_in, run_request,
    output ready
  );
endinterface

// ----- design/olsr_out_if.sv -----
// result channel: references and status of one control period
`timescale 1ns / 1ps
interface olsr_out_if;
  import olsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [QW-1:0]     q_ref;
  logic [AngOutW-1:0]       angle_out;
  logic [BusOutW-1:0]       bus_out;
  logic signed [SpeedW-1:0] speed_now;
  logic                     driving;
  logic [ErrW-1:0]          error_code;

  modport source (
    output valid, q_ref, angle_out, bus_out, speed_now, driving, error_code,
    input  ready
  );
  modport sink (
    input  valid, q_ref, angle_out, bus_out, speed_now, driving, error_code,
    output ready
  );
endinterface

// ----- design/olsr_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps
interface olsr_cfg_if;
  import olsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- design/olsr_seq.sv -----
// microcode sequencer: step counter, control store and conditional jump
`timescale 1ns / 1ps
module olsr_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_blocked,
  input  logic              running,
  output olsr_pkg::seq_ctl_t ctl,
  output logic              busy
);
  import olsr_pkg::*;

  logic [PcW-1:0] pc;
  ctrl_t          word;
  logic           stall;

  assign word     = prog_word(pc);
  // the finishing step waits for room in the result register
  assign stall    = word.finish && out_blocked;
  assign ctl.word = word;
  assign ctl.fire = busy && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_MUL_BUS;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= STEP_MUL_BUS;
      end
    end else if (ctl.fire) begin
      if (word.last) begin
        busy <= 1'b0;
      end else if (word.jmp_nrun && !running) begin
        pc <= word.jmp_to;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end
endmodule

// ----- design/open_loop_speed_ramp_angle_gen_unit.sv -----
// open-loop motor speed ramp and angle generator, top level
`timescale 1ns / 1ps
// one item at a time: the next item is taken only after its six-step control program
//   finishes; the program shares one 24x16 multiplier and skips the angle step when stopped
// a waiting result stalls only the last step; the next item is taken once it is stored
// reset: registers to defaults, speed/angle/target cleared, no mode yet, not running
module open_loop_speed_ramp_angle_gen_unit #(
  parameter int ANGLE_BITS = olsr_pkg::AngleBitsDef,
  parameter int ADC_BITS   = olsr_pkg::AdcBitsDef
) (
  input logic         clk,
  input logic         rst,
  olsr_in_if.sink     samples,
  olsr_out_if.source  refs,
  olsr_cfg_if.sink    cfg
);
  import olsr_pkg::*;

  // only the low ADC_BITS of the 12-bit samples count
  localparam int AdcUse = (ADC_BITS < RawW) ? ADC_BITS : RawW;
  localparam logic [RawW-1:0] AdcMask = RawW'((1 << AdcUse) - 1);
  localparam int AngExtW = 56;

  // configuration registers
  logic [StepW-1:0]     ramp_threshold;
  logic [StepW-1:0]     accel_step;
  logic [StepW-1:0]     decel_step;
  logic [GainW-1:0]     speed_gain;
  logic [GainW-1:0]     bus_gain;
  logic [GainW-1:0]     angle_gain;
  logic signed [QW-1:0] q_current_setting;

  // item held during its program
  logic [RawW-1:0]  in_speed_raw;
  logic [RawW-1:0]  in_bus_raw;
  logic [ModeW-1:0] in_mode;
  logic             in_fault;
  logic             in_run;

  // controller state
  logic signed [SpeedW-1:0] speed_set;
  logic signed [SpeedW-1:0] speed_target;
  logic [RawW-1:0]          last_speed_raw;
  logic [ANGLE_BITS-1:0]    angle_acc;
  logic [DirW-1:0]          direction;
  logic [ModeW-1:0]         motor_mode;
  logic signed [QW-1:0]     q_hold;
  logic                     running;

  // datapath
  logic [MulW-1:0]    prod;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [BusOutW-1:0] bus_val;
  logic [ErrW-1:0]    err_code;
  logic [SpeedW-1:0]  speed_u;
  logic [SpeedW-1:0]  speed_mag;

  // result register
  logic                     out_valid;
  logic signed [QW-1:0]     res_q_ref;
  logic [AngOutW-1:0]       res_angle;
  logic [BusOutW-1:0]       res_bus;
  logic signed [SpeedW-1:0] res_speed;
  logic                     res_driving;
  logic [ErrW-1:0]          res_err;

  seq_ctl_t ctl;
  logic     busy;
  logic     take_item;

  assign take_item     = samples.valid && samples.ready;
  assign samples.ready = !busy;
  assign cfg.ready     = 1'b1;

  olsr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (take_item),
    .out_blocked(out_valid && !refs.ready),
    .running    (running),
    .ctl        (ctl),
    .busy       (busy)
  );

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_threshold    <= RstRampThreshold;
      accel_step        <= RstAccelStep;
      decel_step        <= RstDecelStep;
      speed_gain        <= RstSpeedGain;
      bus_gain          <= RstBusGain;
      angle_gain        <= RstAngleGain;
      q_current_setting <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RAMP_THRESHOLD: ramp_threshold    <= cfg.data;
        REG_ACCEL_STEP:     accel_step        <= cfg.data;
        REG_DECEL_STEP:     decel_step        <= cfg.data;
        REG_SPEED_GAIN:     speed_gain        <= cfg.data[GainW-1:0];
        REG_BUS_GAIN:       bus_gain          <= cfg.data[GainW-1:0];
        REG_ANGLE_GAIN:     angle_gain        <= cfg.data[GainW-1:0];
        REG_Q_CURRENT:      q_current_setting <= $signed(cfg.data[QW-1:0]);
        default: ;
      endcase
    end
  end

  // latch the item when it is taken
  always_ff @(posedge clk) begin
    if (take_item) begin
      in_speed_raw <= samples.speed_raw & AdcMask;
      in_bus_raw   <= samples.bus_raw & AdcMask;
      in_mode      <= samples.req_mode;
      in_fault     <= samples.fault_in;
      in_run       <= samples.run_request;
    end
  end

  // magnitude of the setpoint, -2^23 maps to 2^23
  assign speed_u   = speed_set;
  assign speed_mag = speed_u[SpeedW-1] ? (SpeedW'(0) - speed_u) : speed_u;

  // shared multiplier operand select
  always_comb begin
    case (ctl.word.mul_op)
      MUL_BUS: begin
        mul_a = MulAW'(in_bus_raw);
        mul_b = bus_gain;
      end
      MUL_SPD: begin
        mul_a = MulAW'(in_speed_raw);
        mul_b = speed_gain;
      end
      MUL_ANG: begin
        mul_a = speed_mag;
        mul_b = angle_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && (ctl.word.mul_op != MUL_NONE)) begin
      prod <= mul_a * mul_b;
    end
  end

  // scaled bus voltage, >>12 with saturation at 16 bits
  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.word.take_bus) begin
      bus_val <= (|prod[MulW-1:28]) ? {BusOutW{1'b1}} : prod[27:12];
    end
  end

  // ramp toward the target
  logic signed [SpeedW:0]   ramp_diff;
  logic signed [SpeedW:0]   ramp_limit;
  logic signed [SpeedW:0]   ramp_up;
  logic signed [SpeedW:0]   ramp_down;
  logic signed [SpeedW-1:0] ramp_next;

  always_comb begin
    ramp_diff  = {speed_target[SpeedW-1], speed_target} - {speed_set[SpeedW-1], speed_set};
    ramp_limit = $signed({2'b00, ramp_threshold});
    ramp_up    = {speed_set[SpeedW-1], speed_set} + $signed({2'b00, accel_step});
    ramp_down  = {speed_set[SpeedW-1], speed_set} - $signed({2'b00, decel_step});
    if (ramp_diff == '0) begin
      ramp_next = speed_set;
    end else if (ramp_diff >= ramp_limit) begin
      ramp_next = sat_speed(ramp_up);
    end else if (ramp_diff <= -ramp_limit) begin
      ramp_next = sat_speed(ramp_down);
    end else begin
      ramp_next = speed_target;
    end
  end

  // angle integration from the registered |speed| * gain product
  logic [31:0]           step_wide;
  logic [ANGLE_BITS-1:0] angle_step;
  logic                  angle_neg;
  logic                  angle_moves;
  logic [ANGLE_BITS-1:0] angle_after;
  logic [AngExtW-1:0]    angle_ext;
  logic                  drive;

  always_comb begin
    step_wide   = 32'(prod[MulW-1:16]);
    angle_step  = step_wide[ANGLE_BITS-1:0];
    angle_neg   = speed_set[SpeedW-1] != (direction == DIR_CCW);
    angle_moves = running && ((direction == DIR_CW) || (direction == DIR_CCW));
    if (!angle_moves) begin
      angle_after = angle_acc;
    end else if (angle_neg) begin
      angle_after = angle_acc - angle_step;
    end else begin
      angle_after = angle_acc + angle_step;
    end
    // top 24 bits of the angle, zero-filled below when narrower
    angle_ext = AngExtW'({angle_after, 24'd0});
    drive     = running && !in_fault;
  end

  // controller state updates, one program step at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_set      <= '0;
      speed_target   <= '0;
      last_speed_raw <= '0;
      angle_acc      <= '0;
      direction      <= DIR_STILL;
      motor_mode     <= MODE_NONE;
      q_hold         <= '0;
      running        <= 1'b0;
      err_code       <= ERR_NONE;
    end else if (ctl.fire) begin
      if (ctl.word.update) begin
        // new raw speed, new target
        if (in_speed_raw != last_speed_raw) begin
          last_speed_raw <= in_speed_raw;
          speed_target   <= $signed({8'd0, prod[27:12]});
        end
        // mode change: reset setpoint, take direction and q reference
        if ((in_mode != motor_mode) && (in_mode inside {[MODE_FREE:MODE_CCW]})) begin
          speed_set  <= '0;
          q_hold     <= (in_mode == MODE_FREE) ? '0 : q_current_setting;
          direction  <= (in_mode == MODE_CW)  ? DIR_CW :
                        (in_mode == MODE_CCW) ? DIR_CCW : DIR_STILL;
          motor_mode <= in_mode;
        end
        // run request, start refused without bus voltage
        if (in_run != running) begin
          if (!in_run) begin
            running <= 1'b0;
          end else if (in_bus_raw != '0) begin
            running <= 1'b1;
          end
        end
        // invalid mode wins over missing bus
        if ((in_mode != motor_mode) && !(in_mode inside {[MODE_FREE:MODE_CCW]})) begin
          err_code <= ERR_MODE;
        end else if (in_run && !running && (in_bus_raw == '0)) begin
          err_code <= ERR_NO_BUS;
        end else begin
          err_code <= ERR_NONE;
        end
      end
      if (ctl.word.ramp && running) begin
        speed_set <= ramp_next;
      end
      if (ctl.word.finish && running) begin
        angle_acc <= angle_after;
        // a fault drops the target
        if (in_fault) begin
          speed_target <= '0;
        end
      end
    end
  end

  // result register, refilled only when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (refs.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.fire && ctl.word.finish) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.word.finish) begin
      res_q_ref   <= drive ? q_hold : '0;
      res_angle   <= drive ? angle_ext[ANGLE_BITS+23 -: AngOutW] : '0;
      res_bus     <= drive ? bus_val : '0;
      res_speed   <= speed_set;
      res_driving <= drive;
      res_err     <= err_code;
    end
  end

  assign refs.valid      = out_valid;
  assign refs.q_ref      = res_q_ref;
  assign refs.angle_out  = res_angle;
  assign refs.bus_out    = res_bus;
  assign refs.speed_now  = res_speed;
  assign refs.driving    = res_driving;
  assign refs.error_code = res_err;
endmodule

// ----- design/olsr_check.sv -----
// port-level checks of the speed ramp angle generator, bound to the top level
`timescale 1ns / 1ps
`include "open_loop_speed_ramp_angle_gen_unit_assert.svh"
module olsr_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [olsr_pkg::QW-1:0]     q_ref,
  input logic [olsr_pkg::AngOutW-1:0]       angle_out,
  input logic [olsr_pkg::BusOutW-1:0]       bus_out,
  input logic signed [olsr_pkg::SpeedW-1:0] speed_now,
  input logic                               driving,
  input logic [olsr_pkg::ErrW-1:0]          error_code
);
  import olsr_pkg::*;

  // a taken item keeps the block busy for at least the next cycle
  `OLSR_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "item taken while busy")

  // references are zero unless driving
  `OLSR_ASSERT_NOW(a_refs_zero_idle, out_valid && !driving, (q_ref == '0) && (angle_out == '0) && (bus_out == '0), "references not zero while not driving")

  // only defined error codes leave the block
  `OLSR_ASSERT_NOW(a_err_code_known, out_valid, (error_code == ERR_NONE) || (error_code == ERR_MODE) || (error_code == ERR_NO_BUS), "undefined error code")

  // a stalled result holds
  `OLSR_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(speed_now) && $stable(q_ref) && $stable(driving), "stalled result changed")
endmodule

bind open_loop_speed_ramp_angle_gen_unit olsr_check u_olsr_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (refs.valid),
  .out_ready (refs.ready),
  .q_ref     (refs.q_ref),
  .angle_out (refs.angle_out),
  .bus_out   (refs.bus_out),
  .speed_now (refs.speed_now),
  .driving   (refs.driving),
  .error_code(refs.error_code)
);

// ----- tb/sv/tb_open_loop_speed_ramp_angle_gen_unit.sv -----
// self-checking testbench of the open-loop speed ramp and angle generator
`timescale 1ns / 1ps
module tb_open_loop_speed_ramp_angle_gen_unit;
  import olsr_pkg::*;

  // invalid mode requests used by the stimulus (4 to 7 are rejected)
  localparam logic [ModeW-1:0] MODE_FIRST_BAD = 3'd4;
  localparam logic [ModeW-1:0] MODE_BAD       = 3'd5;

  // one control period as offered on the input channel
  typedef struct packed {
    logic [RawW-1:0]  speed_raw;
    logic [RawW-1:0]  bus_raw;
    logic [ModeW-1:0] req_mode;
    logic             fault_in;
    logic             run_request;
  } period_in_t;

  // references and status that one period must produce
  typedef struct packed {
    logic signed [QW-1:0]     q_ref;
    logic [AngOutW-1:0]       angle_out;
    logic [BusOutW-1:0]       bus_out;
    logic signed [SpeedW-1:0] speed_now;
    logic                     driving;
    logic [ErrW-1:0]          error_code;
  } period_refs_t;

  logic clk;
  logic rst;

  olsr_in_if  samples_ch ();
  olsr_out_if refs_ch ();
  olsr_cfg_if cfg_ch ();

  open_loop_speed_ramp_angle_gen_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .refs    (refs_ch),
    .cfg     (cfg_ch)
  );

  // periods waiting to be offered, and the references still owed by the block
  period_in_t   periods_todo[$];
  period_refs_t refs_due[$];
  period_in_t   drv_item;
  period_refs_t got_due;

  // register copy as the block should hold it
  logic [StepW-1:0]     thr_reg, accel_reg, decel_reg;
  logic [GainW-1:0]     spd_gain_reg, bus_gain_reg, ang_gain_reg;
  logic signed [QW-1:0] q_set_reg;

  // drive state as the block should hold it
  logic signed [SpeedW-1:0] speed_set, speed_target;
  logic [RawW-1:0]          last_raw;
  logic [AngOutW-1:0]       turn_angle;
  logic [DirW-1:0]          rot_dir;
  logic [ModeW-1:0]         cur_mode;
  logic signed [QW-1:0]     q_latched;
  logic                     motor_on;

  // traffic shaping
  logic in_took;
  logic idle_on;
  int   rx_hold_left;

  // run bookkeeping
  int mismatches;
  int periods_checked;
  int driving_seen;
  int errors_seen;
  int faults_while_on;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d periods still owed", refs_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction: one control period, written against the local state copy
  // ---------------------------------------------------------------------------
  function automatic period_refs_t predict_period(input period_in_t p);
    period_refs_t   r;
    longint         bus_v;
    longint         gap;
    longint         nxt;
    longint         mag;
    logic [ErrW-1:0] err;
    logic [AngOutW-1:0] step;
    logic           neg;
    logic           drive;
    bus_v = (longint'(p.bus_raw) * longint'(bus_gain_reg)) >>> 12;
    if (bus_v > 65535) begin
      bus_v = 65535;
    end
    // a new raw speed sample rescales the target; the product always fits in 24 bits
    if (p.speed_raw != last_raw) begin
      last_raw     = p.speed_raw;
      speed_target = SpeedW'((longint'(p.speed_raw) * longint'(spd_gain_reg)) >>> 12);
    end
    err = ERR_NONE;
    // a differing mode request either switches mode or is flagged as invalid
    if (p.req_mode != cur_mode) begin
      if (p.req_mode <= MODE_CCW) begin
        speed_set = '0;
        q_latched = (p.req_mode == MODE_FREE) ? '0 : q_set_reg;
        rot_dir   = (p.req_mode == MODE_CW) ? DIR_CW :
                    (p.req_mode == MODE_CCW) ? DIR_CCW : DIR_STILL;
        cur_mode  = p.req_mode;
      end else begin
        err = ERR_MODE;
      end
    end
    // starting needs bus voltage; the mode error wins the error code
    if (p.run_request != motor_on) begin
      if (p.run_request) begin
        if (p.bus_raw != '0) begin
          motor_on = 1'b1;
        end else if (err == ERR_NONE) begin
          err = ERR_NO_BUS;
        end
      end else begin
        motor_on = 1'b0;
      end
    end
    drive = 1'b0;
    if (motor_on) begin
      // ramp by a step when the gap reaches the threshold, else snap to target
      gap = longint'(speed_target) - longint'(speed_set);
      if (gap != 0) begin
        if (gap >= longint'(thr_reg)) begin
          nxt = longint'(speed_set) + longint'(accel_reg);
        end else if (gap <= -longint'(thr_reg)) begin
          nxt = longint'(speed_set) - longint'(decel_reg);
        end else begin
          nxt = longint'(speed_target);
        end
        if (nxt > 8388607) begin
          nxt = 8388607;
        end else if (nxt < -8388608) begin
          nxt = -8388608;
        end
        speed_set = nxt[SpeedW-1:0];
      end
      // angle integrates |speed| * gain >> 16, sign from speed and direction
      if (rot_dir == DIR_CW || rot_dir == DIR_CCW) begin
        mag = (speed_set < 0) ? -longint'(speed_set) : longint'(speed_set);
        mag = (mag * longint'(ang_gain_reg)) >>> 16;
        step = mag[AngOutW-1:0];
        neg  = (speed_set < 0) != (rot_dir == DIR_CCW);
        turn_angle = neg ? turn_angle - step : turn_angle + step;
      end
      if (p.fault_in) begin
        speed_target = '0;
        faults_while_on++;
      end else begin
        drive = 1'b1;
      end
    end
    r.q_ref      = drive ? q_latched : '0;
    r.angle_out  = drive ? turn_angle : '0;
    r.bus_out    = drive ? BusOutW'(bus_v) : '0;
    r.speed_now  = speed_set;
    r.driving    = drive;
    r.error_code = err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: driver at the falling edge, acceptance at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (!samples_ch.valid || in_took) begin
      // slot is free: offer the next period unless this cycle idles
      if (periods_todo.size() != 0 && !(idle_on && $urandom_range(0, 99) < 26)) begin
        drv_item = periods_todo.pop_front();
        samples_ch.valid       <= 1'b1;
        samples_ch.speed_raw   <= drv_item.speed_raw;
        samples_ch.bus_raw     <= drv_item.bus_raw;
        samples_ch.req_mode    <= drv_item.req_mode;
        samples_ch.fault_in    <= drv_item.fault_in;
        samples_ch.run_request <= drv_item.run_request;
      end else begin
        samples_ch.valid <= 1'b0;
      end
    end
  end

  // every accepted period is predicted at once; registers only change while idle
  always @(posedge clk) begin
    in_took <= !rst && samples_ch.valid && samples_ch.ready;
    if (!rst && samples_ch.valid && samples_ch.ready) begin
      refs_due.push_back(predict_period('{samples_ch.speed_raw, samples_ch.bus_raw,
                                          samples_ch.req_mode, samples_ch.fault_in,
                                          samples_ch.run_request}));
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst || rx_hold_left != 0) begin
      refs_ch.ready <= 1'b0;
    end else begin
      refs_ch.ready <= !(idle_on && $urandom_range(0, 99) < 26);
    end
  end

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // results are compared in order against the oldest owed period
  always @(posedge clk) begin
    if (!rst && refs_ch.valid && refs_ch.ready) begin
      if (refs_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got q %0d angle %0d speed %0d err %0d",
                 $time, refs_ch.q_ref, refs_ch.angle_out, refs_ch.speed_now,
                 refs_ch.error_code);
        mismatches++;
      end else begin
        got_due = refs_due.pop_front();
        check_field("q_ref", got_due.q_ref, refs_ch.q_ref);
        check_field("angle_out", got_due.angle_out, refs_ch.angle_out);
        check_field("bus_out", got_due.bus_out, refs_ch.bus_out);
        check_field("speed_now", got_due.speed_now, refs_ch.speed_now);
        check_field("driving", got_due.driving, refs_ch.driving);
        check_field("error_code", got_due.error_code, refs_ch.error_code);
        periods_checked++;
        if (got_due.driving) begin
          driving_seen++;
        end
        if (got_due.error_code != ERR_NONE) begin
          errors_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_period(input logic [RawW-1:0] spd, input logic [RawW-1:0] bus,
                              input logic [ModeW-1:0] mode, input logic fault,
                              input logic run);
    periods_todo.push_back('{spd, bus, mode, fault, run});
  endtask

  // blocks until no period is pending, in flight or owed
  task automatic wait_idle();
    do @(posedge clk);
    while (periods_todo.size() != 0 || samples_ch.valid || refs_due.size() != 0);
  endtask

  // one register write; the local copy follows at the handshake edge
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    case (idx)
      REG_RAMP_THRESHOLD: thr_reg      = val[StepW-1:0];
      REG_ACCEL_STEP:     accel_reg    = val[StepW-1:0];
      REG_DECEL_STEP:     decel_reg    = val[StepW-1:0];
      REG_SPEED_GAIN:     spd_gain_reg = val[GainW-1:0];
      REG_BUS_GAIN:       bus_gain_reg = val[GainW-1:0];
      REG_ANGLE_GAIN:     ang_gain_reg = val[GainW-1:0];
      REG_Q_CURRENT:      q_set_reg    = val[QW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [StepW-1:0] thr, input logic [StepW-1:0] acc,
                               input logic [StepW-1:0] dec, input logic [GainW-1:0] sg,
                               input logic [GainW-1:0] bg, input logic [GainW-1:0] ag,
                               input logic [QW-1:0] q);
    write_reg(REG_RAMP_THRESHOLD, CfgDataW'(thr));
    write_reg(REG_ACCEL_STEP, CfgDataW'(acc));
    write_reg(REG_DECEL_STEP, CfgDataW'(dec));
    write_reg(REG_SPEED_GAIN, CfgDataW'(sg));
    write_reg(REG_BUS_GAIN, CfgDataW'(bg));
    write_reg(REG_ANGLE_GAIN, CfgDataW'(ag));
    write_reg(REG_Q_CURRENT, CfgDataW'(q));
    settings_used++;
  endtask

  // mostly coherent drive episodes (one mode, held speed command, steady run)
  // with some pure noise periods mixed in
  task automatic queue_random_periods(input int n);
    int               left;
    int               len;
    int               pick;
    logic [RawW-1:0]  spd;
    logic [RawW-1:0]  bus;
    logic [ModeW-1:0] mode;
    logic             run;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_period(RawW'($urandom), RawW'($urandom), ModeW'($urandom),
                     1'($urandom), 1'($urandom));
        left--;
      end else begin
        if (pick < 70) begin
          mode = $urandom_range(0, 1) ? MODE_CW : MODE_CCW;
        end else if (pick < 90) begin
          mode = $urandom_range(0, 1) ? MODE_FREE : MODE_STOP;
        end else begin
          mode = ModeW'($urandom_range(MODE_FIRST_BAD, MODE_NONE));
        end
        spd = RawW'($urandom);
        bus = ($urandom_range(0, 9) == 0) ? '0 : RawW'($urandom_range(1, 4095));
        len = $urandom_range(4, 40);
        if (len > left) begin
          len = left;
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            spd = RawW'($urandom);
          end
          run = (i < len - 1) ? ($urandom_range(0, 24) != 0) : 1'($urandom);
          queue_period(spd, bus, mode, $urandom_range(0, 19) == 0, run);
        end
        left -= len;
      end
    end
  endtask

  task automatic load_random_settings();
    load_settings(StepW'($urandom_range(0, 6000)), StepW'($urandom_range(0, 3000)),
                  StepW'($urandom_range(0, 3000)), GainW'($urandom),
                  GainW'($urandom), GainW'($urandom), QW'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                    = 1'b1;
    samples_ch.valid       = 1'b0;
    samples_ch.speed_raw   = '0;
    samples_ch.bus_raw     = '0;
    samples_ch.req_mode    = MODE_FREE;
    samples_ch.fault_in    = 1'b0;
    samples_ch.run_request = 1'b0;
    refs_ch.ready          = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_RAMP_THRESHOLD;
    cfg_ch.data            = '0;
    in_took                = 1'b0;
    idle_on                = 1'b1;
    rx_hold_left           = 0;
    mismatches             = 0;
    periods_checked        = 0;
    driving_seen           = 0;
    errors_seen            = 0;
    faults_while_on        = 0;
    settings_used          = 1;

    // power-up contents of registers and drive state
    thr_reg      = RstRampThreshold;
    accel_reg    = RstAccelStep;
    decel_reg    = RstDecelStep;
    spd_gain_reg = RstSpeedGain;
    bus_gain_reg = RstBusGain;
    ang_gain_reg = RstAngleGain;
    q_set_reg    = '0;
    speed_set    = '0;
    speed_target = '0;
    last_raw     = '0;
    turn_angle   = '0;
    rot_dir      = DIR_STILL;
    cur_mode     = MODE_NONE;
    q_latched    = '0;
    motor_on     = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: default ramp with a nonzero q setting
    write_reg(REG_Q_CURRENT, CfgDataW'(16'sd1500));
    queue_period(12'd0, 12'd0, MODE_NONE, 1'b0, 1'b0);        // no mode yet, nothing changes
    queue_period(12'd4095, 12'd4095, MODE_BAD, 1'b1, 1'b0);   // invalid mode, fault ignored
    queue_period(12'd0, 12'd0, MODE_FREE, 1'b0, 1'b1);        // start with no bus voltage
    queue_period(12'd0, 12'd0, MODE_BAD, 1'b0, 1'b1);         // both errors, mode wins
    queue_period(12'd4095, 12'd4095, MODE_CW, 1'b0, 1'b1);    // cw start, wide gap ramps
    repeat (3) queue_period(12'd4095, 12'd4095, MODE_CW, 1'b0, 1'b1);
    queue_period(12'd4095, 12'd2048, MODE_CW, 1'b1, 1'b1);    // fault while running
    queue_period(12'd4095, 12'd2048, MODE_CW, 1'b0, 1'b1);    // target stays cleared
    queue_period(12'd1000, 12'd2048, MODE_CW, 1'b0, 1'b1);    // small gap snaps
    queue_period(12'd1000, 12'd2048, MODE_CW, 1'b0, 1'b1);    // zero gap
    queue_period(12'd3000, 12'd1, MODE_CCW, 1'b0, 1'b1);      // reverse while running
    queue_period(12'd3000, 12'd1, MODE_CCW, 1'b0, 1'b1);
    queue_period(12'd3000, 12'd1, MODE_BAD, 1'b0, 1'b1);      // invalid mode, keeps running
    queue_period(12'd3000, 12'd4095, MODE_STOP, 1'b0, 1'b1);  // no direction, no angle
    queue_period(12'd3000, 12'd4095, MODE_STOP, 1'b0, 1'b1);
    queue_period(12'd0, 12'd4095, MODE_FREE, 1'b0, 1'b1);     // free forces q to zero
    queue_period(12'd0, 12'd4095, MODE_FREE, 1'b1, 1'b0);     // stop, fault ignored
    queue_period(12'd2048, 12'd0, MODE_CW, 1'b1, 1'b0);
    queue_period(12'd2048, 12'd0, MODE_CW, 1'b0, 1'b1);       // start refused, no bus
    queue_period(12'd4095, 12'd4095, MODE_NONE, 1'b0, 1'b1);  // mode 7 now invalid
    queue_period(12'd4095, 12'd4095, MODE_NONE, 1'b0, 1'b1);
    wait_idle();

    // top extremes: zero threshold, full steps and gains, most negative q
    load_settings('0, '1, '1, '1, '1, '1, 16'h8000);
    queue_period(12'd0, 12'd4095, MODE_CW, 1'b0, 1'b1);       // small gap, full step down at zero threshold
    queue_period(12'd4095, 12'd4095, MODE_CW, 1'b0, 1'b1);    // full step back up
    queue_period(12'd4095, 12'd4095, MODE_CW, 1'b0, 1'b1);    // overshoot, full step saturates
    queue_random_periods(200);
    wait_idle();

    // bottom extremes: threshold never reached, zero steps and gains
    load_settings('1, '0, '0, '0, '0, '0, 16'h7FFF);
    queue_random_periods(150);
    wait_idle();

    // unit steps and gains
    load_settings(23'd1, 23'd1, 23'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    queue_random_periods(150);
    wait_idle();

    // random settings, first with random idling on both sides
    load_random_settings();
    queue_random_periods(230);
    wait_idle();

    // no idling at all: back-to-back periods at full rate
    idle_on = 1'b0;
    load_random_settings();
    queue_random_periods(230);
    wait_idle();
    idle_on = 1'b1;

    // long result hold-off while periods keep coming, so the input stalls
    load_random_settings();
    queue_random_periods(230);
    @(negedge clk);
    rx_hold_left <= 400;
    wait_idle();

    // sender drains fully halfway through the batch
    load_random_settings();
    queue_random_periods(115);
    wait_idle();
    queue_random_periods(115);
    wait_idle();

    load_random_settings();
    queue_random_periods(230);
    wait_idle();

    // let any stray result show up before closing
    repeat (20) @(posedge clk);

    $display("checked %0d periods under %0d register settings", periods_checked,
             settings_used);
    $display("%0d driving, %0d faulted while running, %0d with an error code",
             driving_seen, faults_while_on, errors_seen);
    if (mismatches == 0 && refs_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
